FILE: design/lwedd_pkg.sv
// ----------------------------------------------------------------------------
// lwedd_pkg
// Shared widths, sizes and types for the LWE decapsulation decoder.
// ----------------------------------------------------------------------------
package lwedd_pkg;

  // Number of secret elements and columns.
  localparam int VectorLength = 512;
  // Width that can hold VectorLength - 1 at its upper limit.
  localparam int LenW         = 13;

  localparam int PosW   = 9;
  localparam int ValW   = 25;
  localparam int ModW   = 24;
  localparam int AccW   = 64;
  localparam int ProdW  = 2 * ValW;
  localparam int DiffW  = ValW + 1;
  localparam int StepW  = 7;

  // Only positions that fit the position field can ever be stored.
  localparam int StoreDepth = (VectorLength < (1 << PosW)) ? VectorLength : (1 << PosW);
  localparam int AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  localparam logic [ModW-1:0] ModReset = ModW'(3329);

  // Operation carried by an input item.
  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpAcc    = 2'd1,
    OpFinish = 2'd2,
    OpUnused = 2'd3
  } op_e;

  // Answer of the shared remainder unit.
  typedef struct packed {
    logic            done;
    logic [ModW-1:0] rem;
  } rem_rsp_t;

endpackage

FILE: design/lwe_decapsulation_decode.sv
// ----------------------------------------------------------------------------
// lwe_decapsulation_decode
// Column-wise LWE decryption: secret store, multiply-accumulate and decode.
// ----------------------------------------------------------------------------
// A load item writes the secret store and leaves the block idle. A u item
// reads the store, multiplies and accumulates in steps (memory read,
// multiply, add). For a v item the shared remainder unit reduces one bit
// per cycle, 64 steps for the accumulator and 26 steps for v minus that
// remainder, and the decoded bit then goes to the output register. The
// block takes no item while one is at work; a finished result may wait in
// the output register while the next item is taken. Ignored items (unused
// operation, load or u position beyond the vector) leave the block idle.
// The modulus register can be written at any time the block is idle.
module lwe_decapsulation_decode (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lwedd_pkg::ModW-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         operation_i,
  input  logic [lwedd_pkg::PosW-1:0]         position_i,
  input  logic signed [lwedd_pkg::ValW-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               secret_bit_o,
  output logic [lwedd_pkg::PosW-1:0]         bit_index_o,
  output logic                               last_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SMul    = 3'd1;
  localparam logic [2:0] SAdd    = 3'd2;
  localparam logic [2:0] SStart1 = 3'd3;
  localparam logic [2:0] SWait1  = 3'd4;
  localparam logic [2:0] SStart2 = 3'd5;
  localparam logic [2:0] SWait2  = 3'd6;
  localparam logic [2:0] SEmit   = 3'd7;

  localparam int ShortPad = lwedd_pkg::AccW - lwedd_pkg::DiffW;

  logic [2:0]                          state_q, state_d;
  logic [lwedd_pkg::ModW-1:0]          mod_q;
  logic [lwedd_pkg::ModW-1:0]          q_eff;
  logic [lwedd_pkg::AccW-1:0]          acc_q;
  logic signed [lwedd_pkg::ValW-1:0]   secret_mem [lwedd_pkg::StoreDepth];
  logic signed [lwedd_pkg::ValW-1:0]   rd_q;
  logic signed [lwedd_pkg::ValW-1:0]   val_q;
  logic [lwedd_pkg::PosW-1:0]          pos_q;
  logic signed [lwedd_pkg::ProdW-1:0]  prod_q;
  logic signed [lwedd_pkg::DiffW-1:0]  diff_q;
  logic                                bit_q;
  logic                                out_valid_q;
  logic                                out_bit_q;
  logic [lwedd_pkg::PosW-1:0]          out_idx_q;
  logic                                out_last_q;

  logic                                in_accept;
  logic                                pos_ok;
  logic [lwedd_pkg::AddrW-1:0]         addr;
  logic                                out_free;
  logic                                red_start;
  logic [lwedd_pkg::StepW-1:0]         red_len;
  logic [lwedd_pkg::AccW-1:0]          red_mag;
  lwedd_pkg::rem_rsp_t                 red_rsp;
  logic [lwedd_pkg::AccW-1:0]          acc_mag;
  logic [lwedd_pkg::DiffW-1:0]         diff_mag;
  logic [lwedd_pkg::ModW-1:0]          rem_pos;
  logic [lwedd_pkg::ModW-1:0]          aux;
  logic [lwedd_pkg::ModW-1:0]          w;
  logic [lwedd_pkg::ModW+1:0]          q3;
  logic                                bit_d;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != SIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign pos_ok      = {{(lwedd_pkg::LenW - lwedd_pkg::PosW){1'b0}}, position_i}
                       < lwedd_pkg::LenW'(lwedd_pkg::VectorLength);
  assign addr        = position_i[lwedd_pkg::AddrW-1:0];
  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_eff       = (mod_q < lwedd_pkg::ModW'(2)) ? lwedd_pkg::ModW'(2) : mod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= lwedd_pkg::ModReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mod_q <= cfg_data_i;
    end
  end

  // Secret store: at most one write or one read per accepted item.
  always_ff @(posedge clk_i) begin
    if (in_accept && pos_ok && (operation_i == lwedd_pkg::OpLoad)) begin
      secret_mem[addr] <= value_i;
    end
    if (in_accept && pos_ok && (operation_i == lwedd_pkg::OpAcc)) begin
      rd_q <= secret_mem[addr];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: begin
        if (in_accept) begin
          if ((operation_i == lwedd_pkg::OpAcc) && pos_ok) begin
            state_d = SMul;
          end else if (operation_i == lwedd_pkg::OpFinish) begin
            state_d = SStart1;
          end
        end
      end
      SMul:    state_d = SAdd;
      SAdd:    state_d = SIdle;
      SStart1: state_d = SWait1;
      SWait1: begin
        if (red_rsp.done) begin
          state_d = SStart2;
        end
      end
      SStart2: state_d = SWait2;
      SWait2: begin
        if (red_rsp.done) begin
          state_d = SEmit;
        end
      end
      SEmit: begin
        if (out_free) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Magnitudes fed to the remainder unit; the short pass puts the 26-bit
  // difference at the top of the dividend so only its bits are shifted.
  assign acc_mag  = acc_q[lwedd_pkg::AccW-1] ? (~acc_q + 1'b1) : acc_q;
  assign diff_mag = diff_q[lwedd_pkg::DiffW-1] ? lwedd_pkg::DiffW'(-diff_q)
                                                : lwedd_pkg::DiffW'(diff_q);
  assign red_start = (state_q == SStart1) || (state_q == SStart2);
  assign red_len   = (state_q == SStart1) ? lwedd_pkg::StepW'(lwedd_pkg::AccW)
                                          : lwedd_pkg::StepW'(lwedd_pkg::DiffW);
  assign red_mag   = (state_q == SStart1) ? acc_mag : {diff_mag, {ShortPad{1'b0}}};

  lwedd_rem_unit u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .len_i     (red_len),
    .mag_i     (red_mag),
    .modulus_i (q_eff),
    .rsp_o     (red_rsp)
  );

  // A negative value maps its magnitude remainder r to q - r (zero stays zero).
  always_comb begin
    rem_pos = (red_rsp.rem == '0) ? '0 : (q_eff - red_rsp.rem);
    aux     = acc_q[lwedd_pkg::AccW-1] ? rem_pos : red_rsp.rem;
    w       = diff_q[lwedd_pkg::DiffW-1] ? rem_pos : red_rsp.rem;
    q3      = {1'b0, q_eff, 1'b0} + {2'b00, q_eff};
    bit_d   = (w >= (q_eff >> 2)) && ({2'b00, w} <= (q3 >> 2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (state_q == SAdd) begin
      acc_q <= acc_q + {{(lwedd_pkg::AccW - lwedd_pkg::ProdW){prod_q[lwedd_pkg::ProdW-1]}},
                        prod_q};
    end else if ((state_q == SEmit) && out_free) begin
      acc_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (state_q == SMul) begin
      prod_q <= val_q * rd_q;
    end
    if ((state_q == SWait1) && red_rsp.done) begin
      diff_q <= {val_q[lwedd_pkg::ValW-1], val_q} - $signed({2'b00, aux});
    end
    if ((state_q == SWait2) && red_rsp.done) begin
      bit_q <= bit_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == SEmit) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == SEmit) && out_free) begin
      out_bit_q  <= bit_q;
      out_idx_q  <= pos_q;
      out_last_q <= ({{(lwedd_pkg::LenW - lwedd_pkg::PosW){1'b0}}, pos_q}
                     == lwedd_pkg::LenW'(lwedd_pkg::VectorLength - 1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign secret_bit_o = out_bit_q;
  assign bit_index_o  = out_idx_q;
  assign last_o       = out_last_q;

endmodule

FILE: design/lwedd_rem_unit.sv
// ----------------------------------------------------------------------------
// lwedd_rem_unit
// Shift-subtract remainder unit: one dividend bit per cycle against modulus.
// ----------------------------------------------------------------------------
module lwedd_rem_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lwedd_pkg::StepW-1:0]     len_i,
  input  logic [lwedd_pkg::AccW-1:0]      mag_i,
  input  logic [lwedd_pkg::ModW-1:0]      modulus_i,
  output lwedd_pkg::rem_rsp_t             rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [lwedd_pkg::StepW-1:0]   cnt_q;
  logic [lwedd_pkg::AccW-1:0]    dvd_q;
  logic [lwedd_pkg::ModW-1:0]    rem_q;
  logic [lwedd_pkg::ModW:0]      trial;
  logic [lwedd_pkg::ModW-1:0]    rem_d;

  // The partial remainder stays below the modulus, so the trial value fits
  // one bit more than the modulus.
  always_comb begin
    trial = {rem_q, dvd_q[lwedd_pkg::AccW-1]};
    if (trial >= {1'b0, modulus_i}) begin
      rem_d = lwedd_pkg::ModW'(trial - {1'b0, modulus_i});
    end else begin
      rem_d = trial[lwedd_pkg::ModW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= len_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == lwedd_pkg::StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[lwedd_pkg::AccW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule
